// File: sv/byte_pattern_scanner_top_defines.svh
// ----------------------------------------------------------------------------
// byte_pattern_scanner_top_defines
// assertion macros shared by the scanner top level
// ----------------------------------------------------------------------------
`ifndef BYTE_PATTERN_SCANNER_TOP_DEFINES_SVH
`define BYTE_PATTERN_SCANNER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_pkg
// shared constants, register codes and types of the byte pattern scanner
// ----------------------------------------------------------------------------
package bps_pkg;

  // needle and history sizes (MAX_NEEDLE in 2..16)
  localparam int MAX_NEEDLE = 16;
  localparam int HIST_DEPTH = MAX_NEEDLE - 1;
  localparam int NIDX_W     = $clog2(MAX_NEEDLE);
  localparam int LEN_W      = 5;
  localparam int NEEDLE_W   = 128;
  localparam int ADDR_W     = 64;

  // configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  // result queue
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  // register index codes
  typedef enum logic [1:0] {
    REG_NEEDLE_LOW    = 2'd0,
    REG_NEEDLE_HIGH   = 2'd1,
    REG_NEEDLE_LENGTH = 2'd2,
    REG_FIRST_ONLY    = 2'd3
  } reg_idx_t;

  // configuration seen by the front end
  typedef struct packed {
    logic [NEEDLE_W-1:0] needle;
    logic [LEN_W-1:0]    needle_length;
    logic                first_only;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic [ADDR_W-1:0] match_address;
    logic              match_valid;
    logic              scan_done;
    logic              any_found;
  } res_t;

  // up to two result items pushed by the front end in one cycle
  typedef struct packed {
    logic [1:0] cnt;
    res_t       item0;
    res_t       item1;
  } push_t;

endpackage

// File: sv/bps_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_in_if
// input byte channel: valid/ready handshake with one memory byte per item
// ----------------------------------------------------------------------------
interface bps_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [63:0] byte_address;
  logic        new_slice;
  logic        new_scan;
  logic        last_of_scan;

  modport source (
    output valid, data_byte, byte_address, new_slice, new_scan, last_of_scan,
    input  ready
  );
  modport sink (
    input  valid, data_byte, byte_address, new_slice, new_scan, last_of_scan,
    output ready
  );
endinterface

// File: sv/bps_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_out_if
// result channel: valid/ready handshake with one match or done item
// ----------------------------------------------------------------------------
interface bps_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] match_address;
  logic        match_valid;
  logic        scan_done;
  logic        any_found;

  modport source (
    output valid, match_address, match_valid, scan_done, any_found,
    input  ready
  );
  modport sink (
    input  valid, match_address, match_valid, scan_done, any_found,
    output ready
  );
endinterface

// File: sv/bps_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_cfg
// apb register file holding the needle, its length and the first-only mode
// ----------------------------------------------------------------------------
module bps_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bps_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bps_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bps_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready,
  output bps_pkg::cfg_t                 cfg
);
  import bps_pkg::*;

  logic [63:0]      needle_low_r;
  logic [63:0]      needle_high_r;
  logic [LEN_W-1:0] needle_length_r;
  logic             first_only_r;
  reg_idx_t         reg_idx;
  logic             wr_en;

  // address decode, registers sit on 8-byte boundaries
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_low_r    <= '0;
      needle_high_r   <= '0;
      needle_length_r <= '0;
      first_only_r    <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_NEEDLE_LOW:    needle_low_r    <= pwdata;
        REG_NEEDLE_HIGH:   needle_high_r   <= pwdata;
        REG_NEEDLE_LENGTH: needle_length_r <= pwdata[LEN_W-1:0];
        REG_FIRST_ONLY:    first_only_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_NEEDLE_LOW:    prdata = needle_low_r;
      REG_NEEDLE_HIGH:   prdata = needle_high_r;
      REG_NEEDLE_LENGTH: prdata = CFG_DATA_W'(needle_length_r);
      REG_FIRST_ONLY:    prdata = CFG_DATA_W'(first_only_r);
      default:           prdata = '0;
    endcase
  end

  assign cfg.needle        = {needle_high_r, needle_low_r};
  assign cfg.needle_length = needle_length_r;
  assign cfg.first_only    = first_only_r;

endmodule

// File: sv/bps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_front
// accepts bytes, keeps the slice history and compares every needle position
// in parallel, then pushes the match and done items into the result queue
// ----------------------------------------------------------------------------
module bps_front (
  input  logic            clk,
  input  logic            rst_n,
  bps_in_if.sink          in_chan,
  input  bps_pkg::cfg_t   cfg,
  input  logic            space_ok,
  output bps_pkg::push_t  push
);
  import bps_pkg::*;

  logic [7:0]        hist_r [HIST_DEPTH];
  logic [LEN_W-1:0]  fill_r, fill_nxt;
  logic              found_r, found_nxt;
  logic [ADDR_W-1:0] first_r, first_nxt;

  logic              accept;
  logic [LEN_W-1:0]  len_c, len_m1;
  logic [7:0]        needle_arr [MAX_NEEDLE];
  logic [7:0]        win [MAX_NEEDLE];
  logic [LEN_W-1:0]  sel_idx [MAX_NEEDLE];
  logic [MAX_NEEDLE-1:0] pos_ok;
  logic [LEN_W-1:0]  fill_eff;
  logic              found_eff;
  logic [ADDR_W-1:0] first_eff;
  logic              hit, emit_hit;
  logic [ADDR_W-1:0] start_addr;
  res_t              match_item, done_item;

  assign in_chan.ready = space_ok;
  assign accept        = in_chan.valid && space_ok;

  // clamp the length and line the needle up against the history window
  always_comb begin
    len_c  = (cfg.needle_length > LEN_W'(MAX_NEEDLE)) ? LEN_W'(MAX_NEEDLE)
                                                      : cfg.needle_length;
    len_m1 = len_c - LEN_W'(1);
    win[0] = in_chan.data_byte;
    for (int k = 1; k < MAX_NEEDLE; k++) begin
      win[k] = hist_r[k-1];
    end
    for (int k = 0; k < MAX_NEEDLE; k++) begin
      needle_arr[k] = cfg.needle[8*k +: 8];
      sel_idx[k]    = len_m1 - LEN_W'(k);
      pos_ok[k]     = (LEN_W'(k) >= len_c) ||
                      (win[k] == needle_arr[sel_idx[k][NIDX_W-1:0]]);
    end
  end

  // slice and scan marks, match decision and next state
  always_comb begin
    fill_eff   = (in_chan.new_slice || in_chan.new_scan) ? '0 : fill_r;
    found_eff  = in_chan.new_scan ? 1'b0 : found_r;
    first_eff  = in_chan.new_scan ? '0 : first_r;
    hit        = (len_c != '0) && (fill_eff >= len_m1) && (&pos_ok);
    start_addr = in_chan.byte_address - ADDR_W'(len_m1);
    emit_hit   = hit && !(cfg.first_only && found_eff);
    found_nxt  = found_eff | hit;
    first_nxt  = (hit && !found_eff) ? start_addr : first_eff;
    fill_nxt   = (fill_eff < LEN_W'(HIST_DEPTH)) ? fill_eff + LEN_W'(1) : fill_eff;
  end

  // result items for the queue, match first then done
  always_comb begin
    match_item.match_address = start_addr;
    match_item.match_valid   = 1'b1;
    match_item.scan_done     = 1'b0;
    match_item.any_found     = 1'b0;
    done_item.match_address  = first_nxt;
    done_item.match_valid    = 1'b0;
    done_item.scan_done      = 1'b1;
    done_item.any_found      = found_nxt;
    push.item0 = emit_hit ? match_item : done_item;
    push.item1 = done_item;
    if (accept) begin
      push.cnt = {1'b0, emit_hit} + {1'b0, in_chan.last_of_scan};
    end else begin
      push.cnt = 2'd0;
    end
  end

  // byte history shift line
  always_ff @(posedge clk) begin
    if (accept) begin
      hist_r[0] <= in_chan.data_byte;
      for (int k = 1; k < HIST_DEPTH; k++) begin
        hist_r[k] <= hist_r[k-1];
      end
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      found_r <= 1'b0;
      first_r <= '0;
    end else if (accept) begin
      fill_r  <= fill_nxt;
      found_r <= found_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

// File: sv/bps_rq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_rq
// small result queue between front and back: up to two pushes and one pop a cycle
// ----------------------------------------------------------------------------
module bps_rq (
  input  logic            clk,
  input  logic            rst_n,
  input  bps_pkg::push_t  push,
  input  logic            pop,
  output bps_pkg::res_t   head,
  output logic            not_empty,
  output logic            space_ok
);
  import bps_pkg::*;

  res_t                ent_r [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] head_r, tail_r, tail_p1;
  logic [RQ_CNT_W-1:0] count_r, count_nxt;

  assign tail_p1   = tail_r + RQ_PTR_W'(1);
  assign head      = ent_r[head_r];
  assign not_empty = (count_r != '0);
  assign space_ok  = (count_r <= RQ_CNT_W'(RQ_DEPTH - 2));
  assign count_nxt = count_r + RQ_CNT_W'(push.cnt) - RQ_CNT_W'(pop);

  // entry storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      ent_r[tail_r] <= push.item0;
    end
    if (push.cnt == 2'd2) begin
      ent_r[tail_p1] <= push.item1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_r + RQ_PTR_W'(pop);
      tail_r  <= tail_r + RQ_PTR_W'(push.cnt);
      count_r <= count_nxt;
    end
  end

endmodule

// File: sv/bps_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_back
// drains the result queue into a registered output stage
// ----------------------------------------------------------------------------
module bps_back (
  input  logic           clk,
  input  logic           rst_n,
  input  bps_pkg::res_t  head,
  input  logic           not_empty,
  output logic           pop,
  bps_out_if.source      out_chan
);
  import bps_pkg::*;

  logic valid_r, valid_nxt;
  res_t data_r;

  // load a new item when the stage is empty or being taken
  assign pop       = not_empty && (!valid_r || out_chan.ready);
  assign valid_nxt = pop || (valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= head;
    end
  end

  assign out_chan.valid         = valid_r;
  assign out_chan.match_address = data_r.match_address;
  assign out_chan.match_valid   = data_r.match_valid;
  assign out_chan.scan_done     = data_r.scan_done;
  assign out_chan.any_found     = data_r.any_found;

endmodule

// File: sv/byte_pattern_scanner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_pattern_scanner_top
// streaming exact substring search over memory bytes with an up-to-16-byte needle
// ----------------------------------------------------------------------------
//  channel   kind          carries
//  in_chan   valid/ready   data_byte, byte_address, slice and scan marks
//  out_chan  valid/ready   match_address, match_valid, scan_done, any_found
//  psel..    apb write/rd  needle low/high, needle length, first-only
//
//  one byte is accepted per cycle while the queue has room; all needle positions compare in parallel
//  a byte yields up to two items (match, done) through a 4-entry queue;
//  the output stage sends one item a cycle while out_chan is ready, so match-and-done bytes in a row
//  hold input ready low until the queue drains to two entries
//  an item passes through a queue entry and then the output register; reset is synchronous
//  and needs no clearing pass
// ----------------------------------------------------------------------------
`include "byte_pattern_scanner_top_defines.svh"

module byte_pattern_scanner_top (
  input  logic                           clk,
  input  logic                           rst_n,
  bps_in_if.sink                         in_chan,
  bps_out_if.source                      out_chan,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bps_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bps_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bps_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import bps_pkg::*;

  cfg_t  cfg;
  push_t push;
  res_t  rq_head;
  logic  rq_not_empty, rq_space_ok, rq_pop;
  logic  in_acc;

  assign in_acc = in_chan.valid && in_chan.ready;

  // register file
  bps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // front end: history and compare
  bps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg      (cfg),
    .space_ok (rq_space_ok),
    .push     (push)
  );

  // result queue
  bps_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (rq_pop),
    .head      (rq_head),
    .not_empty (rq_not_empty),
    .space_ok  (rq_space_ok)
  );

  // back end: output stage
  bps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (rq_head),
    .not_empty (rq_not_empty),
    .pop       (rq_pop),
    .out_chan  (out_chan)
  );

  // checks
  `BPS_ASSERT_NOW(a_done_pushed, in_acc && in_chan.last_of_scan, push.cnt != 2'd0, "last byte without done item")
  `BPS_ASSERT_NOW(a_no_push_idle, !in_acc, push.cnt == 2'd0, "push without accepted item")
  `BPS_ASSERT_NOW(a_pair_order, push.cnt == 2'd2, push.item0.match_valid && push.item1.scan_done, "bad item pair order")
  `BPS_ASSERT_NEXT(a_pop_loads, rq_pop, out_chan.valid, "popped item not presented")

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the byte pattern scanner: a few hand-built scans
// (empty needle, address wrap, slice and scan boundaries, oversized length,
// first-only mode) and then random scans over several needle settings. A
// scoreboard class predicts every match and done item and checks the
// results in order. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module tb_top;
  import bps_pkg::*;

  localparam int CLK_HALF_NS   = 4;
  localparam int RESET_CYCLES  = 12;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 16;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_BYTES   = 76;
  localparam int HOLD_CYCLES   = 80;
  localparam int MAX_REPORTS   = 10;

  // one input item as the bench sees it
  typedef struct {
    logic [7:0]        data_byte;
    logic [ADDR_W-1:0] byte_address;
    logic              new_slice;
    logic              new_scan;
    logic              last_of_scan;
  } scan_byte_t;

  // predicts hit and done items from accepted bytes, checks results in order
  class match_scoreboard;
    logic [NEEDLE_W-1:0] needle;
    logic [LEN_W-1:0]    needle_len;
    bit                  first_only;
    logic [7:0]          history [HIST_DEPTH];
    int unsigned         fill;
    bit                  found;
    logic [ADDR_W-1:0]   first_addr;
    res_t                expected_q [$];
    int                  failures;
    int                  match_items;
    int                  done_items;

    function new();
      needle     = '0;
      needle_len = '0;
      first_only = 1'b0;
      foreach (history[i]) history[i] = 8'h00;
      fill        = 0;
      found       = 1'b0;
      first_addr  = '0;
      failures    = 0;
      match_items = 0;
      done_items  = 0;
    endfunction

    function void set_register(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_NEEDLE_LOW:    needle[63:0]   = value;
        REG_NEEDLE_HIGH:   needle[127:64] = value;
        REG_NEEDLE_LENGTH: needle_len     = value[LEN_W-1:0];
        REG_FIRST_ONLY:    first_only     = value[0];
        default: ;
      endcase
    endfunction

    function void note_byte(scan_byte_t b);
      int unsigned       len;
      bit                hit;
      logic [ADDR_W-1:0] start;
      len = (needle_len > MAX_NEEDLE) ? MAX_NEEDLE : needle_len;
      if (b.new_slice || b.new_scan) fill = 0;
      if (b.new_scan) begin
        found      = 1'b0;
        first_addr = '0;
      end
      // window ending at this byte against the needle
      if (len > 0 && fill >= len - 1) begin
        hit = (needle[8*(len-1) +: 8] == b.data_byte);
        for (int k = 1; k < len; k++)
          if (history[k-1] != needle[8*(len-1-k) +: 8]) hit = 1'b0;
        if (hit) begin
          start = b.byte_address - ADDR_W'(len - 1);
          if (!(first_only && found))
            expected_q.insert(expected_q.size(),
                              res_t'{match_address: start, match_valid: 1'b1,
                                     scan_done: 1'b0, any_found: 1'b0});
          if (!found) first_addr = start;
          found = 1'b1;
        end
      end
      // shift history, newest first
      for (int k = HIST_DEPTH - 1; k > 0; k--) history[k] = history[k-1];
      history[0] = b.data_byte;
      if (fill < HIST_DEPTH) fill++;
      if (b.last_of_scan)
        expected_q.insert(expected_q.size(),
                          res_t'{match_address: first_addr, match_valid: 1'b0,
                                 scan_done: 1'b1, any_found: found});
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (got.match_valid) match_items++;
      if (got.scan_done) done_items++;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("[%0t] unexpected item: addr %h match %b done %b found %b",
                   $time, got.match_address, got.match_valid, got.scan_done,
                   got.any_found);
        return;
      end
      want = expected_q.pop_front();
      if (got.match_address !== want.match_address ||
          got.match_valid !== want.match_valid ||
          got.scan_done !== want.scan_done ||
          got.any_found !== want.any_found) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("[%0t] item mismatch: expected addr %h match %b done %b found %b",
                   $time, want.match_address, want.match_valid, want.scan_done,
                   want.any_found);
          $display("  got addr %h match %b done %b found %b",
                   got.match_address, got.match_valid, got.scan_done,
                   got.any_found);
        end
      end
    endfunction

    function void check_drained();
      if (expected_q.size() != 0) begin
        failures++;
        $display("%0d expected items never arrived", expected_q.size());
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  bps_in_if  byte_chan ();
  bps_out_if result_chan ();

  byte_pattern_scanner_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (byte_chan),
    .out_chan (result_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  match_scoreboard     sb;
  scan_byte_t          stim_q [$];
  logic [NEEDLE_W-1:0] stim_needle;
  int unsigned         stim_len;
  int                  plant_pos;
  int                  send_idle_pct;
  int                  recv_stall_pct;
  int                  hold_len;
  int                  holds_done;
  int                  input_stalls;
  int                  bytes_sent;
  int                  settings_used;
  int                  cycle_count;

  // clock
  always begin
    clk = 1'b0;
    #(CLK_HALF_NS);
    clk = 1'b1;
    #(CLK_HALF_NS);
  end

  // cycle budget
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result checking and input stall count
  always @(posedge clk) begin : result_monitor
    res_t got;
    if (rst_n === 1'b1) begin
      if (result_chan.valid && result_chan.ready) begin
        got.match_address = result_chan.match_address;
        got.match_valid   = result_chan.match_valid;
        got.scan_done     = result_chan.scan_done;
        got.any_found     = result_chan.any_found;
        sb.check_result(got);
      end
      if (byte_chan.valid && !byte_chan.ready) input_stalls++;
    end
  end

  // result sink: random stalls, plus long hold-offs on request
  initial begin : result_sink
    int n;
    result_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        n        = hold_len;
        hold_len = 0;
        result_chan.ready <= 1'b0;
        repeat (n) @(posedge clk);
        holds_done++;
      end
      result_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // apb write: setup phase, access phase, then idle
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(8 * int'(idx));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk);
  endtask

  // all four registers; unused upper bits of the length and first-only words get random junk
  task automatic load_setting(input logic [NEEDLE_W-1:0] needle_val,
                              input int len_code, input bit fo);
    logic [CFG_DATA_W-1:0] val;
    write_reg(REG_NEEDLE_LOW, needle_val[63:0]);
    write_reg(REG_NEEDLE_HIGH, needle_val[127:64]);
    val      = {$urandom, $urandom};
    val[4:0] = len_code[4:0];
    write_reg(REG_NEEDLE_LENGTH, val);
    val    = {$urandom, $urandom};
    val[0] = fo;
    write_reg(REG_FIRST_ONLY, val);
    stim_needle = needle_val;
    stim_len    = len_code[4:0];
    plant_pos   = -1;
    settings_used++;
  endtask

  function automatic void queue_byte(logic [7:0] d, logic [ADDR_W-1:0] a,
                                     bit sl, bit sc, bit la);
    stim_q.insert(stim_q.size(), scan_byte_t'{d, a, sl, sc, la});
  endfunction

  // bytes biased toward the needle, with whole copies planted now and then
  function automatic logic [7:0] next_byte();
    logic [7:0]  b;
    int unsigned eff;
    eff = (stim_len > MAX_NEEDLE) ? MAX_NEEDLE : stim_len;
    if (plant_pos < 0 && eff > 0 && $urandom_range(99) < 20) plant_pos = 0;
    if (plant_pos >= 0) begin
      b = stim_needle[8*plant_pos +: 8];
      plant_pos++;
      if (plant_pos >= eff) plant_pos = -1;
    end else if (eff > 0 && $urandom_range(1) == 0) begin
      b = stim_needle[8*$urandom_range(eff - 1) +: 8];
    end else begin
      b = $urandom;
    end
    return b;
  endfunction

  // slice base addresses: zero, near the top, small, or anywhere
  function automatic logic [ADDR_W-1:0] pick_address();
    case ($urandom_range(3))
      0: return '0;
      1: return '1 - ADDR_W'($urandom_range(20));
      2: return ADDR_W'($urandom_range(255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // send queued items, with random gaps before them
  task automatic send_queue();
    scan_byte_t b;
    while (stim_q.size() > 0) begin
      b = stim_q.pop_front();
      if ($urandom_range(99) < send_idle_pct) begin
        byte_chan.valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      byte_chan.valid        <= 1'b1;
      byte_chan.data_byte    <= b.data_byte;
      byte_chan.byte_address <= b.byte_address;
      byte_chan.new_slice    <= b.new_slice;
      byte_chan.new_scan     <= b.new_scan;
      byte_chan.last_of_scan <= b.last_of_scan;
      @(posedge clk);
      while (!byte_chan.ready) @(posedge clk);
      sb.note_byte(b);
      bytes_sent++;
    end
  endtask

  // stop offering, wait for every expected item, then let the pipe empty
  task automatic settle_idle(input int extra);
    byte_chan.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [NEEDLE_W-1:0] needle_val;
    logic [7:0]          sym_a;
    logic [7:0]          sym_b;
    logic [ADDR_W-1:0]   addr;
    int                  len_code;
    int                  n_slices;
    int                  n_bytes;
    int                  phase_start;

    sb                     = new();
    rst_n                  = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    byte_chan.valid        = 1'b0;
    byte_chan.data_byte    = '0;
    byte_chan.byte_address = '0;
    byte_chan.new_slice    = 1'b0;
    byte_chan.new_scan     = 1'b0;
    byte_chan.last_of_scan = 1'b0;
    stim_needle            = '0;
    stim_len               = 0;
    plant_pos              = -1;
    send_idle_pct          = 0;
    recv_stall_pct         = 0;
    hold_len               = 0;
    holds_done             = 0;
    input_stalls           = 0;
    bytes_sent             = 0;
    settings_used          = 0;
    cycle_count            = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting is an empty needle: zero bytes must not match
    queue_byte(8'h00, 64'h0, 1'b1, 1'b1, 1'b0);
    queue_byte(8'h00, 64'h1, 1'b0, 1'b0, 1'b1);
    send_queue();
    settle_idle(SETTLE_CYCLES);

    // needle 00 ff: first hit wraps below address zero, done without new
    // scan, then a slice break that must not match across
    load_setting({$urandom, $urandom, 64'h0000_0000_0000_ff00}, 2, 1'b0);
    queue_byte(8'h00, '1, 1'b1, 1'b1, 1'b0);
    queue_byte(8'hff, 64'h0, 1'b0, 1'b0, 1'b0);
    queue_byte(8'h00, 64'h1, 1'b0, 1'b0, 1'b0);
    queue_byte(8'hff, 64'h2, 1'b0, 1'b0, 1'b1);
    queue_byte(8'h00, 64'h3, 1'b0, 1'b0, 1'b0);
    queue_byte(8'hff, 64'h4, 1'b0, 1'b0, 1'b1);
    queue_byte(8'h00, 64'h100, 1'b1, 1'b0, 1'b0);
    queue_byte(8'hff, 64'h200, 1'b1, 1'b0, 1'b0);
    queue_byte(8'hff, 64'h300, 1'b0, 1'b1, 1'b1);
    send_queue();
    settle_idle(SETTLE_CYCLES);

    // oversized length clamps to the full needle; first-only drops the
    // overlapping second hit; addresses wrap inside the slice
    load_setting({16{8'h5a}}, 31, 1'b1);
    addr = 64'hffff_ffff_ffff_fff8;
    for (int i = 0; i < 17; i++) begin
      queue_byte(8'h5a, addr, i == 0, i == 0, i == 16);
      addr++;
    end
    send_queue();
    settle_idle(SETTLE_CYCLES);

    // random phases over several needle settings and idle mixes
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: len_code = 1;
        1: len_code = MAX_NEEDLE;
        2: len_code = 3;
        3: len_code = 0;
        4: len_code = $urandom_range(MAX_NEEDLE + 1, 31);
        5: len_code = 2;
        default: len_code = $urandom_range(1, MAX_NEEDLE);
      endcase
      if (p % 2 == 0) begin
        // two-symbol needle so hits overlap and repeat
        sym_a = $urandom;
        sym_b = $urandom;
        for (int i = 0; i < MAX_NEEDLE; i++)
          needle_val[8*i +: 8] = ($urandom_range(1) != 0) ? sym_a : sym_b;
      end else begin
        needle_val = {$urandom, $urandom, $urandom, $urandom};
      end
      load_setting(needle_val, len_code, (p % 4 == 1) || (p % 4 == 2));

      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          // receiver holds off while bytes keep coming
          hold_len = HOLD_CYCLES;
        end
        1: begin
          send_idle_pct  = 50;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 50;
        end
        default: begin
          send_idle_pct  = 13;
          recv_stall_pct = 13;
        end
      endcase

      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        if ($urandom_range(99) < 20) begin
          // noise: marks and addresses at random
          n_bytes = $urandom_range(4, 20);
          addr    = pick_address();
          for (int i = 0; i < n_bytes; i++) begin
            if ($urandom_range(3) == 0) addr = {$urandom, $urandom};
            queue_byte(next_byte(), addr, $urandom_range(5) == 0,
                       $urandom_range(11) == 0, $urandom_range(4) == 0);
            addr++;
          end
        end else begin
          // well-formed scan of one to three slices, each at contiguous addresses
          n_slices = $urandom_range(1, 3);
          for (int s = 0; s < n_slices; s++) begin
            n_bytes = $urandom_range(1, 40);
            addr    = pick_address();
            for (int i = 0; i < n_bytes; i++) begin
              queue_byte(next_byte(), addr, i == 0, (s == 0) && (i == 0),
                         (s == n_slices - 1) && (i == n_bytes - 1));
              addr++;
            end
          end
        end
        send_queue();
      end
      settle_idle(SETTLE_CYCLES);
    end

    settle_idle(DRAIN_CYCLES);
    sb.check_drained();
    $display("covered %0d bytes over %0d needle settings: %0d match and %0d done items",
             bytes_sent, settings_used, sb.match_items, sb.done_items);
    $display("input held off for %0d cycles across %0d long receiver hold-offs",
             input_stalls, holds_done);
    if (sb.failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d failures", sb.failures);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: byte_pattern_scanner_top.f
+incdir+sv
sv/bps_pkg.sv
sv/bps_in_if.sv
sv/bps_out_if.sv
sv/bps_cfg.sv
sv/bps_front.sv
sv/bps_rq.sv
sv/bps_back.sv
sv/byte_pattern_scanner_top.sv
test/tb_top.sv
